// File: rtl/rtnp_pkg.sv
// Shared types, character codes and header defaults for the ringtone text note parser.
// Used by ringtone_text_note_parser; depends on nothing.
package rtnp_pkg;

  // Octave offset added to every note octave (0..9), wrapped to 4 bits.
  localparam logic [3:0]  OCTAVE_SHIFT   = 4'd0;

  localparam logic [15:0] DEF_LENGTH     = 16'd4;
  localparam logic [3:0]  DEF_OCTAVE     = 4'd6;
  localparam logic [17:0] DEF_WHOLE_MS   = 18'(((60 * 1000) / 63) * 2);
  localparam logic [17:0] MS_PER_MINUTE  = 18'(60 * 1000);
  localparam logic [15:0] OCTAVE_MIN     = 16'd3;
  localparam logic [15:0] OCTAVE_MAX     = 16'd7;

  // Divider: one quotient bit per cycle over an 18-bit dividend.
  localparam int          DIV_STEPS      = 18;
  localparam logic [4:0]  DIV_LAST       = 5'(DIV_STEPS - 1);

  localparam logic [7:0]  CH_NUL         = 8'h00;
  localparam logic [7:0]  CH_SPACE       = 8'h20;
  localparam logic [7:0]  CH_HASH        = 8'h23;
  localparam logic [7:0]  CH_COMMA       = 8'h2C;
  localparam logic [7:0]  CH_DOT         = 8'h2E;
  localparam logic [7:0]  CH_ZERO        = 8'h30;
  localparam logic [7:0]  CH_NINE        = 8'h39;
  localparam logic [7:0]  CH_COLON       = 8'h3A;
  localparam logic [7:0]  CH_A           = 8'h61;
  localparam logic [7:0]  CH_B           = 8'h62;
  localparam logic [7:0]  CH_C           = 8'h63;
  localparam logic [7:0]  CH_D           = 8'h64;
  localparam logic [7:0]  CH_E           = 8'h65;
  localparam logic [7:0]  CH_F           = 8'h66;
  localparam logic [7:0]  CH_G           = 8'h67;
  localparam logic [7:0]  CH_O           = 8'h6F;

  typedef enum logic [2:0] {
    PH_NAME,
    PH_HKEY,
    PH_HEQ,
    PH_HVAL,
    PH_NDUR,
    PH_NLET,
    PH_NMOD
  } phase_t;

  typedef enum logic [1:0] {
    KEY_NONE,
    KEY_D,
    KEY_O,
    KEY_B
  } hdr_key_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  semitone;
    logic [3:0]  octave;
    logic [17:0] duration_ms;
    logic        song_end;
  } out_word_t;

  // Semitone of a note letter; anything else (including p) is a rest.
  function automatic logic [3:0] letter_code(input logic [7:0] c);
    logic [3:0] code;
    code = 4'd0;
    unique case (c)
      CH_C:    code = 4'd1;
      CH_D:    code = 4'd3;
      CH_E:    code = 4'd5;
      CH_F:    code = 4'd6;
      CH_G:    code = 4'd8;
      CH_A:    code = 4'd10;
      CH_B:    code = 4'd12;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Decimal accumulate, saturating at 16 bits.
  function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
    logic [19:0] ext;
    logic [19:0] v;
    ext = {4'b0, acc};
    v   = (ext << 3) + (ext << 1) + {16'b0, 4'(c - CH_ZERO)};
    return (v > 20'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// File: rtl/ringtone_text_note_parser.sv
// Ringtone text note parser: top level, character parser plus one shared divider.
// Depends on rtnp_pkg for word types, character codes and header defaults.
//
// Usage:
//   in_valid/in_ready/in_data carry one song text byte per word (ch) plus
//   start_req, which restarts parsing with header defaults at that byte.
//   out_valid/out_ready/out_data carry result words: one note (semitone,
//   octave, duration_ms) per ',' or NUL that closes a note, and an end
//   marker (song_end = 1, other fields zero) after every NUL while parsing.
// Sequencing:
//   A byte that only changes parser state leaves the sequencer idle. A byte
//   that closes a note or a b= header field runs the shared restoring divider,
//   one quotient bit per cycle, and the block takes no new byte until it is
//   through with that one; the end marker is written after the note word (or
//   straight from idle for a bare NUL). in_ready is high only while the
//   sequencer is idle.
// Reset:
//   rst clears the sequencer and output valid, loads header defaults
//   (length 4, octave 6, 1904 ms whole note) and leaves the parser stopped;
//   bytes give no result until one arrives with start_req set.
// Stall:
//   The output register holds its word until taken. While the sequencer is
//   idle the parser keeps taking bytes that give no result; a byte that gives
//   one waits in the sequencer, blocking input, until the output register frees up.
module ringtone_text_note_parser
  import rtnp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_NOTE,
    S_END
  } seq_state_t;

  seq_state_t  state;

  // Parser state
  phase_t      phase;
  hdr_key_t    hdr_key;
  logic [15:0] number_acc;
  logic [15:0] default_length;
  logic [3:0]  default_octave;
  logic [17:0] whole_note_ms;
  logic [3:0]  pending_semitone;
  logic        pending_dotted;
  logic [3:0]  pending_octave;
  logic        octave_given;
  logic        playing;

  // Job captured for the sequencer
  logic        job_is_bpm;
  logic        job_end;
  logic [3:0]  job_semitone;
  logic [3:0]  job_octave;
  logic        job_dotted;

  // Shared divider
  logic [15:0] div_rem;
  logic [17:0] div_q;
  logic [15:0] div_den;
  logic [4:0]  div_cnt;

  // Next parser values for an accepted byte
  phase_t      phase_next;
  hdr_key_t    hdr_key_next;
  logic [15:0] number_acc_next;
  logic [15:0] default_length_next;
  logic [3:0]  default_octave_next;
  logic [17:0] whole_note_ms_next;
  logic [3:0]  pending_semitone_next;
  logic        pending_dotted_next;
  logic [3:0]  pending_octave_next;
  logic        octave_given_next;
  logic        playing_next;

  logic        emit_note;
  logic        emit_end;
  logic        run_bpm;
  logic        key_byte;
  logic [15:0] bpm_den;
  logic [15:0] note_len;
  logic [3:0]  note_octave;

  logic [16:0] rem_sh;
  logic        q_bit;
  logic [15:0] rem_new;
  logic [17:0] q_new;
  logic [18:0] dur_sum;
  logic        out_free;
  logic        out_load;

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;
  assign out_load = ((state == S_NOTE) || (state == S_END)) && out_free;

  // Note length and octave come from the state before this byte; a byte
  // that closes a note never also carries start_req effects into them.
  always_comb begin
    note_len = (number_acc == 16'd0) ? default_length : number_acc;
    if (note_len == 16'd0) begin
      note_len = 16'd1;
    end
    note_octave = (octave_given ? pending_octave : default_octave) + OCTAVE_SHIFT;
  end

  // Byte parser: next state for one accepted word.
  always_comb begin
    phase_next            = phase;
    hdr_key_next          = hdr_key;
    number_acc_next       = number_acc;
    default_length_next   = default_length;
    default_octave_next   = default_octave;
    whole_note_ms_next    = whole_note_ms;
    pending_semitone_next = pending_semitone;
    pending_dotted_next   = pending_dotted;
    pending_octave_next   = pending_octave;
    octave_given_next     = octave_given;
    playing_next          = playing;
    emit_note             = 1'b0;
    emit_end              = 1'b0;
    run_bpm               = 1'b0;
    key_byte              = 1'b0;
    bpm_den               = (number_acc == 16'd0) ? 16'd1 : number_acc;

    if (in_data.start_req) begin
      hdr_key_next          = KEY_NONE;
      number_acc_next       = 16'd0;
      default_length_next   = DEF_LENGTH;
      default_octave_next   = DEF_OCTAVE;
      whole_note_ms_next    = DEF_WHOLE_MS;
      pending_semitone_next = 4'd0;
      pending_dotted_next   = 1'b0;
      pending_octave_next   = 4'd0;
      octave_given_next     = 1'b0;
      phase_next            = PH_NAME;
      playing_next          = 1'b1;
    end

    if (playing_next) begin
      if (in_data.ch == CH_NUL) begin
        emit_note             = (phase_next == PH_NLET) || (phase_next == PH_NMOD);
        emit_end              = 1'b1;
        playing_next          = 1'b0;
        phase_next            = PH_NAME;
        number_acc_next       = 16'd0;
        pending_semitone_next = 4'd0;
        pending_dotted_next   = 1'b0;
        pending_octave_next   = 4'd0;
        octave_given_next     = 1'b0;
      end else begin
        unique case (phase_next)
          PH_NAME: begin
            if (in_data.ch == CH_COLON) begin
              phase_next   = PH_HKEY;
              hdr_key_next = KEY_NONE;
            end
          end
          PH_HKEY: begin
            key_byte = 1'b1;
          end
          PH_HEQ: begin
            number_acc_next = 16'd0;
            phase_next      = PH_HVAL;
          end
          PH_HVAL: begin
            if (is_digit(in_data.ch)) begin
              number_acc_next = acc_digit(number_acc_next, in_data.ch);
            end else begin
              // Close the header field; bpm goes to the divider.
              unique case (hdr_key_next)
                KEY_D: begin
                  if (number_acc_next != 16'd0) begin
                    default_length_next = number_acc_next;
                  end
                end
                KEY_O: begin
                  if (number_acc_next >= OCTAVE_MIN && number_acc_next <= OCTAVE_MAX) begin
                    default_octave_next = number_acc_next[3:0];
                  end
                end
                KEY_B:    run_bpm = 1'b1;
                KEY_NONE: ;
                default:  ;
              endcase
              hdr_key_next = KEY_NONE;
              phase_next   = PH_HKEY;
              key_byte     = 1'b1;
            end
          end
          PH_NDUR: begin
            if (is_digit(in_data.ch)) begin
              number_acc_next = acc_digit(number_acc_next, in_data.ch);
            end else if (in_data.ch != CH_SPACE && in_data.ch != CH_COMMA) begin
              pending_semitone_next = letter_code(in_data.ch);
              phase_next            = PH_NLET;
            end
          end
          default: begin
            if (in_data.ch == CH_COMMA) begin
              emit_note             = 1'b1;
              number_acc_next       = 16'd0;
              pending_semitone_next = 4'd0;
              pending_dotted_next   = 1'b0;
              pending_octave_next   = 4'd0;
              octave_given_next     = 1'b0;
              phase_next            = PH_NDUR;
            end else if (in_data.ch == CH_HASH) begin
              if (phase_next == PH_NLET) begin
                pending_semitone_next = pending_semitone_next + 4'd1;
                phase_next            = PH_NMOD;
              end
            end else if (in_data.ch == CH_DOT) begin
              pending_dotted_next = 1'b1;
              phase_next          = PH_NMOD;
            end else if (is_digit(in_data.ch)) begin
              pending_octave_next = 4'(in_data.ch - CH_ZERO);
              octave_given_next   = 1'b1;
              phase_next          = PH_NMOD;
            end
          end
        endcase

        if (key_byte) begin
          if (in_data.ch == CH_COLON) begin
            phase_next            = PH_NDUR;
            number_acc_next       = 16'd0;
            pending_semitone_next = 4'd0;
            pending_dotted_next   = 1'b0;
            pending_octave_next   = 4'd0;
            octave_given_next     = 1'b0;
          end else if (in_data.ch == CH_D) begin
            hdr_key_next = KEY_D;
            phase_next   = PH_HEQ;
          end else if (in_data.ch == CH_O) begin
            hdr_key_next = KEY_O;
            phase_next   = PH_HEQ;
          end else if (in_data.ch == CH_B) begin
            hdr_key_next = KEY_B;
            phase_next   = PH_HEQ;
          end
        end
      end
    end
  end

  // One restoring divide step: shift in the next dividend bit, trial subtract.
  always_comb begin
    rem_sh  = {div_rem, div_q[17]};
    q_bit   = (rem_sh >= {1'b0, div_den});
    rem_new = q_bit ? 16'(rem_sh - {1'b0, div_den}) : rem_sh[15:0];
    q_new   = {div_q[16:0], q_bit};
    // Dotted note adds half, rounded down.
    dur_sum = {1'b0, div_q} + (job_dotted ? {2'b0, div_q[17:1]} : 19'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      phase            <= PH_NAME;
      hdr_key          <= KEY_NONE;
      number_acc       <= 16'd0;
      default_length   <= DEF_LENGTH;
      default_octave   <= DEF_OCTAVE;
      whole_note_ms    <= DEF_WHOLE_MS;
      pending_semitone <= 4'd0;
      pending_dotted   <= 1'b0;
      pending_octave   <= 4'd0;
      octave_given     <= 1'b0;
      playing          <= 1'b0;
      job_is_bpm       <= 1'b0;
      job_end          <= 1'b0;
      div_cnt          <= 5'd0;
    end else begin
      // Load a new word when the register frees up, else drop a taken one.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            phase            <= phase_next;
            hdr_key          <= hdr_key_next;
            number_acc       <= number_acc_next;
            default_length   <= default_length_next;
            default_octave   <= default_octave_next;
            whole_note_ms    <= whole_note_ms_next;
            pending_semitone <= pending_semitone_next;
            pending_dotted   <= pending_dotted_next;
            pending_octave   <= pending_octave_next;
            octave_given     <= octave_given_next;
            playing          <= playing_next;

            // Hold the closed note's fields for the result word.
            job_is_bpm   <= run_bpm;
            job_end      <= emit_end;
            job_semitone <= pending_semitone;
            job_octave   <= note_octave;
            job_dotted   <= pending_dotted;

            div_rem <= 16'd0;
            div_cnt <= DIV_LAST;
            if (run_bpm) begin
              div_q   <= MS_PER_MINUTE;
              div_den <= bpm_den;
            end else begin
              div_q   <= whole_note_ms;
              div_den <= note_len;
            end

            priority if (emit_note || run_bpm) begin
              state <= S_DIV;
            end else if (emit_end) begin
              state <= S_END;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          div_rem <= rem_new;
          div_q   <= q_new;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            if (job_is_bpm) begin
              whole_note_ms <= {q_new[16:0], 1'b0};
              state         <= S_IDLE;
            end else begin
              state <= S_NOTE;
            end
          end
        end
        S_NOTE: begin
          if (out_free) begin
            out_data.semitone    <= job_semitone;
            out_data.octave      <= job_octave;
            out_data.duration_ms <= dur_sum[17:0];
            out_data.song_end    <= 1'b0;
            state                <= job_end ? S_END : S_IDLE;
          end
        end
        S_END: begin
          if (out_free) begin
            out_data.semitone    <= 4'd0;
            out_data.octave      <= 4'd0;
            out_data.duration_ms <= 18'd0;
            out_data.song_end    <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
